// ===== src/efms_pkg.sv =====
// ----------------------------------------------------------------------------
// efms_pkg
// Shared constants and types for the earliest-free-machine scheduler.
// ----------------------------------------------------------------------------
package efms_pkg;

    localparam int TIME_W           = 32;
    localparam int FIELD_W          = 31;
    localparam int CFG_W            = 5;
    localparam int DEF_MAX_MACHINES = 16;

    localparam logic [TIME_W-1:0] TIME_SAT = '1;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic              clear;
        logic              load;
        logic [TIME_W-1:0] finish;
    } cell_ctrl_t;

    // What a cell hands to its left neighbor.
    typedef struct packed {
        logic              lt;
        logic [TIME_W-1:0] value;
    } cell_link_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CALC   = 3'b010,
        ST_INSERT = 3'b100
    } state_t;

endpackage

// ===== src/efms_cell.sv =====
// ----------------------------------------------------------------------------
// efms_cell
// One slot of the sorted free-time chain. On a load the chain drops its head
// and takes the new finish time in sorted place: each cell picks its right
// neighbor, the new value, or keeps its own.
// ----------------------------------------------------------------------------
module efms_cell
    import efms_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  cell_link_t       right,
    output cell_link_t       left
);

    logic [TIME_W-1:0] value_reg;
    logic [TIME_W-1:0] value_next;
    logic              active;
    logic              own_lt;

    assign active = (count > CNT_W'(INDEX));
    assign own_lt = active && (value_reg < ctrl.finish);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.clear)
        begin
            value_next = '0;
        end
        else if (ctrl.load && active)
        begin
            if (right.lt)
            begin
                value_next = right.value;
            end
            else if ((INDEX == 0) || own_lt)
            begin
                value_next = ctrl.finish;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign left.lt    = own_lt;
    assign left.value = value_reg;

endmodule

// ===== src/earliest_free_machine_scheduler.sv =====
// ----------------------------------------------------------------------------
// earliest_free_machine_scheduler
// List scheduler: each job goes to the machine that frees up first. Free
// times live in a sorted chain of cells whose head is the earliest one.
//
//   channel  handshake            payload
//   job in   start, busy          release_time, duration
//   result   done (strobe)        job_finish, makespan, overflow
//   config   cfg_valid, cfg_ready cfg_data (machine count)
//
// A job takes two steps: the first adds its duration to the later of the head
// free time and its release time, the second lets the chain drop the head and
// insert the finish time. busy is high for both steps and the result strobe is
// in the second; busy then goes low in idle, so a new job is taken only once
// the last one is through. A machine count write clears the chain and the
// makespan. Reset leaves one machine, and all free times and the makespan at
// zero. The result cannot be stalled.
// ----------------------------------------------------------------------------
module earliest_free_machine_scheduler
    import efms_pkg::*;
#(
    parameter int MAX_MACHINES = DEF_MAX_MACHINES
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] release_time,
    input  logic [FIELD_W-1:0] duration,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               done,
    output logic [TIME_W-1:0]  job_finish,
    output logic [TIME_W-1:0]  makespan,
    output logic               overflow
);

    localparam int CNT_W = $clog2(MAX_MACHINES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [FIELD_W-1:0] release_reg;
    logic [FIELD_W-1:0] duration_reg;
    logic [TIME_W-1:0]  finish_reg;
    logic [TIME_W-1:0]  makespan_reg;
    logic               overflow_reg;
    logic               done_reg;

    logic               accept;
    logic               cfg_write;
    logic [31:0]        cfg_ext;
    logic [CNT_W-1:0]   cfg_count;
    logic [TIME_W-1:0]  head;
    logic [TIME_W-1:0]  begin_time;
    logic [TIME_W:0]    sum;
    logic [TIME_W-1:0]  finish_calc;
    cell_ctrl_t         ctrl;

    cell_link_t         links [MAX_MACHINES+1];

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // Machine count of zero means one; above the chain length means all.
    always_comb
    begin
        cfg_ext = 32'(cfg_data);
        if (cfg_ext == 32'd0)
        begin
            cfg_count = CNT_W'(1);
        end
        else if (cfg_ext > 32'(MAX_MACHINES))
        begin
            cfg_count = CNT_W'(MAX_MACHINES);
        end
        else
        begin
            cfg_count = cfg_ext[CNT_W-1:0];
        end
    end

    assign head        = links[0].value;
    assign begin_time  = (TIME_W'(release_reg) > head) ? TIME_W'(release_reg) : head;
    assign sum         = {1'b0, begin_time} + (TIME_W+1)'(duration_reg);
    assign finish_calc = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_CALC;
            ST_CALC:   state_next = ST_INSERT;
            ST_INSERT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= CNT_W'(1);
            makespan_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_CALC);
            if (cfg_write)
            begin
                count_reg    <= cfg_count;
                makespan_reg <= '0;
            end
            else if (state_reg == ST_CALC && finish_calc > makespan_reg)
            begin
                makespan_reg <= finish_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            release_reg  <= release_time;
            duration_reg <= duration;
        end
        if (state_reg == ST_CALC)
        begin
            finish_reg   <= finish_calc;
            overflow_reg <= sum[TIME_W];
        end
    end

    assign ctrl.clear  = cfg_write;
    assign ctrl.load   = (state_reg == ST_INSERT);
    assign ctrl.finish = finish_reg;

    assign links[MAX_MACHINES].lt    = 1'b0;
    assign links[MAX_MACHINES].value = '0;

    for (genvar i = 0; i < MAX_MACHINES; i++)
    begin : g_cell
        efms_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .count (count_reg),
            .right (links[i+1]),
            .left  (links[i])
        );
    end

    assign done       = done_reg;
    assign job_finish = finish_reg;
    assign makespan   = makespan_reg;
    assign overflow   = overflow_reg;

    // The result beat comes only in the cycle the chain takes the insert.
    a_done_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == ST_INSERT))
        else $error("result strobe outside insert cycle");

    a_makespan_covers: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (makespan >= job_finish))
        else $error("makespan below job finish");

    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (job_finish == TIME_SAT))
        else $error("overflow without saturated finish");

    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CALC))
        else $error("accepted job did not start");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> (makespan_reg == '0 && head == '0))
        else $error("config write did not clear schedule");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the earliest-free-machine scheduler. Jobs go in over
// the start/busy handshake with random gaps. A predictor keeps its own table
// of machine free times and the makespan, and it computes the finish time of
// each accepted job. Every result strobe is compared with the oldest
// prediction. The machine count is rewritten between phases, only while
// the scheduler is idle. The machine counts cover zero, the maximum and
// values beyond it.
// ----------------------------------------------------------------------------
module testbench;
    import efms_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_JOBS  = 125;
    localparam int NUM_PHASES  = 8;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0] finish;
        logic [TIME_W-1:0] span;
        logic              sat;
    } job_outcome_t;

    // Mirrors the machine table and predicts one outcome per accepted job.
    class machine_schedule_model;
        logic [TIME_W-1:0] free_at [DEF_MAX_MACHINES];
        logic [TIME_W-1:0] latest;
        int unsigned       machines;
        job_outcome_t      pending_finishes [$];
        int                errors;
        int                jobs_seen;
        int                results_seen;
        int                saturations;

        function new();
            errors       = 0;
            jobs_seen    = 0;
            results_seen = 0;
            saturations  = 0;
            machines     = 1;
            clear_table();
        endfunction

        function void clear_table();
            foreach (free_at[i]) free_at[i] = '0;
            latest = '0;
        endfunction

        // A count of zero means one machine; anything above the table size
        // is clipped to the table size.
        function void set_machines(logic [CFG_W-1:0] count);
            if (count == 0)
                machines = 1;
            else if (count > DEF_MAX_MACHINES)
                machines = DEF_MAX_MACHINES;
            else
                machines = count;
            clear_table();
        endfunction

        function void accept_job(logic [FIELD_W-1:0] rel, logic [FIELD_W-1:0] dur);
            int unsigned       best;
            logic [TIME_W-1:0] begin_at;
            logic [TIME_W:0]   total;
            job_outcome_t      o;
            best = 0;
            for (int i = 1; i < machines; i++)
                if (free_at[i] < free_at[best])
                    best = i;
            begin_at = free_at[best];
            if ({1'b0, rel} > begin_at)
                begin_at = {1'b0, rel};
            total = {1'b0, begin_at} + {2'b00, dur};
            if (total[TIME_W]) begin
                o.finish = TIME_SAT;
                o.sat    = 1'b1;
            end else begin
                o.finish = total[TIME_W-1:0];
                o.sat    = 1'b0;
            end
            free_at[best] = o.finish;
            if (o.finish > latest)
                latest = o.finish;
            o.span = latest;
            pending_finishes.push_back(o);
            jobs_seen++;
        endfunction

        function void check_finish(logic [TIME_W-1:0] finish, logic [TIME_W-1:0] span,
                                   logic sat);
            job_outcome_t want;
            results_seen++;
            if (pending_finishes.size() == 0) begin
                $display("%0t: result with no job waiting: finish %h makespan %h ovf %b",
                         $time, finish, span, sat);
                errors++;
                return;
            end
            want = pending_finishes.pop_front();
            if (want.sat)
                saturations++;
            if (finish !== want.finish) begin
                $display("%0t: job_finish expected %h actual %h", $time, want.finish, finish);
                errors++;
            end
            if (span !== want.span) begin
                $display("%0t: makespan expected %h actual %h", $time, want.span, span);
                errors++;
            end
            if (sat !== want.sat) begin
                $display("%0t: overflow expected %b actual %b", $time, want.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [FIELD_W-1:0] release_time;
    logic [FIELD_W-1:0] duration;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data;
    logic               done;
    logic [TIME_W-1:0]  job_finish;
    logic [TIME_W-1:0]  makespan;
    logic               overflow;

    machine_schedule_model board = new();
    int                    cycles = 0;
    int                    settings_used = 0;
    logic [TIME_W-1:0]     horizon;

    earliest_free_machine_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .release_time (release_time),
        .duration     (duration),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .job_finish   (job_finish),
        .makespan     (makespan),
        .overflow     (overflow)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitors sample the values that stood before the edge. A count write
    // in the same beat as a job takes effect before that job.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            board.set_machines(cfg_data);
        if (rst_n && start && !busy)
            board.accept_job(release_time, duration);
        if (rst_n && done)
            board.check_finish(job_finish, makespan, overflow);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Leaves start high; the caller lowers it only when a gap follows.
    task automatic send_job(input logic [FIELD_W-1:0] rel, input logic [FIELD_W-1:0] dur);
        start        <= 1'b1;
        release_time <= rel;
        duration     <= dur;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause_jobs(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_schedule();
        start <= 1'b0;
        while (board.pending_finishes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_machines(input logic [CFG_W-1:0] count);
        drain_schedule();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        horizon = '0;
        settings_used++;
    endtask

    // Release times follow a moving horizon so that the table does not just
    // saturate; the window width sets how fast times grow.
    task automatic send_random_job(input int span_bits);
        logic [FIELD_W-1:0] mask;
        logic [TIME_W-1:0]  rel;
        logic [FIELD_W-1:0] dur;
        int                 pick;
        mask = (span_bits >= FIELD_W) ? FIELD_MAX : FIELD_W'((32'd1 << span_bits) - 1);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            rel = $urandom_range(0, 1) ? {1'b0, FIELD_MAX} : '0;
            dur = $urandom_range(0, 1) ? FIELD_MAX : '0;
        end else if (pick == 1) begin
            rel = {1'b0, FIELD_W'($urandom)};
            dur = FIELD_W'($urandom);
        end else begin
            rel = horizon + {1'b0, FIELD_W'($urandom) & mask};
            dur = FIELD_W'($urandom) & mask;
            horizon = horizon + {1'b0, (FIELD_W'($urandom) & mask) >> 2};
            if (horizon > {1'b0, FIELD_MAX})
                horizon = '0;
        end
        if (rel > {1'b0, FIELD_MAX})
            rel = {1'b0, FIELD_MAX};
        send_job(rel[FIELD_W-1:0], dur);
    endtask

    initial
    begin
        logic [CFG_W-1:0] phase_counts [NUM_PHASES];
        int               phase_spans  [NUM_PHASES];

        rst_n        <= 1'b0;
        start        <= 1'b0;
        release_time <= '0;
        duration     <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        horizon       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One machine after reset: later release, overflow and saturated start.
        send_job('0, '0);
        send_job(31'd5, 31'd10);
        send_job('0, 31'd3);
        send_job(31'd100, '0);
        send_job(FIELD_MAX, FIELD_MAX);
        send_job('0, FIELD_MAX);
        send_job(FIELD_MAX, '0);

        // Four machines: equal free times, then the earliest one is reused.
        write_machines(5'd4);
        send_job('0, 31'd7);
        send_job('0, 31'd7);
        send_job(31'h2AAAAAAA, 31'h55555555);
        send_job(31'd3, 31'd1);

        // A count of zero runs as one machine.
        write_machines(5'd0);
        send_job(31'd1, 31'd1);

        // Count above the table size: seventeen jobs fill sixteen machines.
        write_machines(5'd31);
        for (int i = 0; i < 17; i++)
            send_job('0, 31'd1);

        phase_counts = '{5'd17, 5'd1, 5'd16, CFG_W'($urandom_range(2, 15)),
                         5'd3, 5'd8, 5'd16, 5'd5};
        phase_spans  = '{10, 20, 12, 16, 31, 8, 24, 14};
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_machines(phase_counts[p]);
            for (int j = 0; j < PHASE_JOBS; j++) begin
                send_random_job(phase_spans[p]);
                // Phase two runs back to back with no gaps.
                if (p != 2 && $urandom_range(0, 99) < 30)
                    pause_jobs($urandom_range(1, 5));
            end
        end

        drain_schedule();
        repeat (10) @(posedge clk);

        $display("Scheduled %0d jobs under %0d machine-count writes, %0d results checked.",
                 board.jobs_seen, settings_used, board.results_seen);
        $display("%0d finish times saturated, %0d mismatches.",
                 board.saturations, board.errors);
        if (board.errors == 0 && board.pending_finishes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
